[rtl/shs_pkg.sv]
// shared types, opcodes, register map and phase table of the half-step sequencer
`default_nettype none
package shs_pkg;

  // field widths
  localparam int OP_W     = 3;
  localparam int COUNT_W  = 24;
  localparam int AMOUNT_W = 16;
  localparam int TOOTH_W  = 8;
  localparam int COIL_W   = 4;
  localparam int PHASE_W  = 3;
  localparam int DELAY_W  = 16;
  localparam int SPT_W    = 16;

  // move counts reach 32768 * 65535, which fits in 31 bits
  localparam int CNT_W    = 31;
  // magnitude of position sums, at most 33021
  localparam int ABS_W    = 16;

  // configuration port
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  // opcodes
  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 3'd0,
    OP_STEP     = 3'd1,
    OP_ROTATE   = 3'd2,
    OP_TEETH    = 3'd3,
    OP_MOVE_TO  = 3'd4,
    OP_STOP     = 3'd5
  } op_t;

  // register indexes (word address)
  localparam logic [1:0] REG_STEP_DELAY  = 2'd0;
  localparam logic [1:0] REG_STEPS_TURN  = 2'd1;
  localparam logic [1:0] REG_TEETH_TURN  = 2'd2;
  localparam logic [1:0] REG_LOOP_TEETH  = 2'd3;

  // register reset values
  localparam logic [DELAY_W-1:0] RST_STEP_DELAY  = 16'd2;
  localparam logic [SPT_W-1:0]   RST_STEPS_TURN  = 16'd8192;
  localparam logic [TOOTH_W-1:0] RST_TEETH_TURN  = 8'd16;
  localparam logic [TOOTH_W-1:0] RST_LOOP_TEETH  = 8'd32;

  // coil pattern of each half-step phase, bit0 is IN1
  function automatic logic [COIL_W-1:0] phase_pattern(input logic [PHASE_W-1:0] idx);
    logic [COIL_W-1:0] pat;
    case (idx)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

[rtl/shs_stream_if.sv]
// valid/ready channels for command items and result items
`default_nettype none
interface shs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [shs_pkg::OP_W-1:0]             op;
  logic [shs_pkg::COUNT_W-1:0]          step_count;
  logic                                 direction;
  logic signed [shs_pkg::AMOUNT_W-1:0]  signed_amount;
  logic [shs_pkg::TOOTH_W-1:0]          target_tooth;

  modport source (
    output valid, op, step_count, direction, signed_amount, target_tooth,
    input  ready
  );
  modport sink (
    input  valid, op, step_count, direction, signed_amount, target_tooth,
    output ready
  );
endinterface

interface shs_out_if;
  logic                          valid;
  logic                          ready;
  logic [shs_pkg::COIL_W-1:0]    coils;
  logic                          busy_res;
  logic [shs_pkg::TOOTH_W-1:0]   tooth_position;
  logic                          accepted;
  logic [shs_pkg::PHASE_W-1:0]   phase;

  modport source (
    output valid, coils, busy_res, tooth_position, accepted, phase,
    input  ready
  );
  modport sink (
    input  valid, coils, busy_res, tooth_position, accepted, phase,
    output ready
  );
endinterface
`default_nettype wire

[rtl/stepper_half_step_sequencer.sv]
// top level: half-step sequencer for a four-coil unipolar stepper on a chain drive
`default_nettype none
// Every transfer on in_ch (a tick or a command) yields exactly one transfer on out_ch
// with the coil drive, busy flag, chain tooth position, accepted flag and phase index.
// Items are handled one at a time by a small sequencer around a single restoring
// divider that retires one quotient bit per cycle. A tick, stop, ignored item or a
// command refused while busy goes from decode to the result; an accepted step passes
// through the start state; rotate_rounds adds one registered 16x16 multiply; move_teeth
// and move_to_position add the multiply, a divider pass for the step count quotient,
// then another for the position modulo the loop tooth count. A result that waits for
// out_ch.ready keeps the next item in its last state until the output register frees;
// in_ch is ready again at the same edge that writes a result into the output register.
// Registers sit on the APB port at byte addresses 0, 4, 8 and 12; pready is always
// high and reads need no wait.
module stepper_half_step_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  shs_in_if.sink                             in_ch,
  shs_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [shs_pkg::APB_AW-1:0]    paddr,
  input  wire logic [shs_pkg::APB_DW-1:0]    pwdata,
  output logic      [shs_pkg::APB_DW-1:0]    prdata,
  output logic                               pready
);

  localparam int CW = shs_pkg::CNT_W;
  localparam int AW = shs_pkg::ABS_W;
  localparam int TW = shs_pkg::TOOTH_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_DIVQ,
    S_DIVR,
    S_START,
    S_FINISH
  } state_t;

  // configuration registers
  logic [shs_pkg::DELAY_W-1:0] step_delay_r;
  logic [shs_pkg::SPT_W-1:0]   steps_turn_r;
  logic [TW-1:0]               teeth_turn_r;
  logic [TW-1:0]               loop_teeth_r;

  // latched item
  state_t                             state_r;
  logic [shs_pkg::OP_W-1:0]           op_r;
  logic [shs_pkg::COUNT_W-1:0]        count_in_r;
  logic                               dir_in_r;
  logic signed [shs_pkg::AMOUNT_W-1:0] amount_r;
  logic [TW-1:0]                      target_r;
  logic                               acc_r;

  // motion state
  logic [shs_pkg::PHASE_W-1:0]  phase_r;
  logic                         energised_r;
  logic [CW-1:0]                steps_left_r;
  logic [shs_pkg::DELAY_W-1:0]  delay_left_r;
  logic                         moving_r;
  logic [TW-1:0]                chain_r;
  logic                         ccw_r;

  // command working registers
  logic signed [AW:0]           teeth_r;
  logic signed [AW+1:0]         sum_r;
  logic [CW-1:0]                move_cnt_r;
  logic                         cmd_ccw_r;

  // shared divider
  logic [CW-1:0]                quo_r;
  logic [TW-1:0]                rem_r;
  logic [TW-1:0]                div_r;
  logic [4:0]                   iter_r;

  // output register
  logic                         out_valid_r;
  logic [shs_pkg::COIL_W-1:0]   coils_r;
  logic                         busy_r;
  logic [TW-1:0]                tooth_r;
  logic                         acc_out_r;
  logic [shs_pkg::PHASE_W-1:0]  phase_out_r;

  // ---------------- configuration port ----------------

  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  // register writes, zero handling per register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_delay_r  <= shs_pkg::RST_STEP_DELAY;
      steps_turn_r  <= shs_pkg::RST_STEPS_TURN;
      teeth_turn_r  <= shs_pkg::RST_TEETH_TURN;
      loop_teeth_r  <= shs_pkg::RST_LOOP_TEETH;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        shs_pkg::REG_STEP_DELAY: begin
          step_delay_r <= (pwdata[15:0] == '0) ? 16'd1 : pwdata[15:0];
        end
        shs_pkg::REG_STEPS_TURN: begin
          if (pwdata[15:0] != '0) steps_turn_r <= pwdata[15:0];
        end
        shs_pkg::REG_TEETH_TURN: begin
          if (pwdata[7:0] != '0) teeth_turn_r <= pwdata[7:0];
        end
        default: begin
          if (pwdata[7:0] != '0) loop_teeth_r <= pwdata[7:0];
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      shs_pkg::REG_STEP_DELAY: prdata = {16'd0, step_delay_r};
      shs_pkg::REG_STEPS_TURN: prdata = {16'd0, steps_turn_r};
      shs_pkg::REG_TEETH_TURN: prdata = {24'd0, teeth_turn_r};
      default:                 prdata = {24'd0, loop_teeth_r};
    endcase
  end

  // ---------------- datapath helpers ----------------

  logic                         in_xfer;
  logic                         out_free;
  logic [TW-1:0]                tgt_clamped;
  logic signed [AW:0]           teeth_to;
  logic signed [AW+1:0]         sum_teeth;
  logic signed [AW:0]           teeth_neg;
  logic [AW-1:0]                teeth_mag;
  logic [31:0]                  prod_full;
  logic signed [AW+1:0]         sum_neg;
  logic [AW-1:0]                sum_mag;
  logic [TW:0]                  div_trial;
  logic [TW:0]                  div_diff;
  logic                         div_ge;
  logic [TW-1:0]                rem_nxt;
  logic [CW-1:0]                quo_nxt;
  logic [TW-1:0]                pos_nxt;
  logic [shs_pkg::DELAY_W-1:0]  delay_dec;
  logic [shs_pkg::PHASE_W-1:0]  phase_up;
  logic [shs_pkg::PHASE_W-1:0]  phase_dn;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // move_to_position: clamp target and take the tooth difference
  assign tgt_clamped = (target_r >= loop_teeth_r) ? loop_teeth_r - 8'd1 : target_r;
  assign teeth_to    = $signed({9'd0, tgt_clamped}) - $signed({9'd0, chain_r});
  assign sum_teeth   = $signed({10'd0, chain_r}) + $signed({{2{amount_r[15]}}, amount_r});

  // magnitude and product with steps per turn
  assign teeth_neg = -teeth_r;
  assign teeth_mag = teeth_r[AW] ? teeth_neg[AW-1:0] : teeth_r[AW-1:0];
  assign prod_full = teeth_mag * steps_turn_r;

  assign sum_neg = -sum_r;
  assign sum_mag = sum_r[AW+1] ? sum_neg[AW-1:0] : sum_r[AW-1:0];

  // one restoring divide step
  assign div_trial = {rem_r, quo_r[CW-1]};
  assign div_diff  = div_trial - {1'b0, div_r};
  assign div_ge    = (div_trial >= {1'b0, div_r});
  assign rem_nxt   = div_ge ? div_diff[TW-1:0] : div_trial[TW-1:0];
  assign quo_nxt   = {quo_r[CW-2:0], div_ge};

  // floor modulo from the magnitude remainder
  assign pos_nxt = (sum_r[AW+1] && (rem_nxt != '0)) ? loop_teeth_r - rem_nxt : rem_nxt;

  assign delay_dec = (delay_left_r != '0) ? delay_left_r - 16'd1 : delay_left_r;
  assign phase_up  = phase_r + 3'd1;
  assign phase_dn  = phase_r - 3'd1;

  // ---------------- sequencer ----------------

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= '0;
      energised_r  <= 1'b0;
      steps_left_r <= '0;
      delay_left_r <= '0;
      moving_r     <= 1'b0;
      chain_r      <= '0;
      ccw_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      acc_r        <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_FINISH)) out_valid_r <= 1'b0;

      unique case (state_r)
        // take an item
        S_IDLE: begin
          if (in_xfer) begin
            op_r       <= in_ch.op;
            count_in_r <= in_ch.step_count;
            dir_in_r   <= in_ch.direction;
            amount_r   <= in_ch.signed_amount;
            target_r   <= in_ch.target_tooth;
            acc_r      <= 1'b0;
            state_r    <= S_DECODE;
          end
        end

        // dispatch on opcode
        S_DECODE: begin
          case (op_r) inside
            shs_pkg::OP_TICK: begin
              if (moving_r) begin
                if (delay_dec == '0) begin
                  if (steps_left_r != '0) begin
                    phase_r      <= ccw_r ? phase_dn : phase_up;
                    energised_r  <= 1'b1;
                    steps_left_r <= steps_left_r - 31'd1;
                    delay_left_r <= step_delay_r;
                  end else begin
                    delay_left_r <= delay_dec;
                    moving_r     <= 1'b0;
                  end
                end else begin
                  delay_left_r <= delay_dec;
                end
              end
              state_r <= S_FINISH;
            end
            shs_pkg::OP_STOP: begin
              energised_r  <= 1'b0;
              moving_r     <= 1'b0;
              steps_left_r <= '0;
              delay_left_r <= '0;
              acc_r        <= 1'b1;
              state_r      <= S_FINISH;
            end
            shs_pkg::OP_STEP, shs_pkg::OP_ROTATE, shs_pkg::OP_TEETH,
            shs_pkg::OP_MOVE_TO: begin
              if (moving_r) begin
                state_r <= S_FINISH;
              end else begin
                acc_r <= 1'b1;
                if (op_r == shs_pkg::OP_STEP) begin
                  move_cnt_r <= CW'(count_in_r);
                  cmd_ccw_r  <= dir_in_r;
                  state_r    <= S_START;
                end else if (op_r == shs_pkg::OP_MOVE_TO) begin
                  teeth_r   <= teeth_to;
                  sum_r     <= $signed({10'd0, tgt_clamped});
                  cmd_ccw_r <= teeth_to[AW];
                  state_r   <= S_MUL;
                end else begin
                  teeth_r   <= {amount_r[15], amount_r};
                  sum_r     <= sum_teeth;
                  cmd_ccw_r <= amount_r[15];
                  state_r   <= S_MUL;
                end
              end
            end
            default: begin
              state_r <= S_FINISH;
            end
          endcase
        end

        // magnitude times steps per turn
        S_MUL: begin
          if (op_r == shs_pkg::OP_ROTATE) begin
            move_cnt_r <= prod_full[CW-1:0];
            state_r    <= S_START;
          end else begin
            quo_r   <= prod_full[CW-1:0];
            rem_r   <= '0;
            div_r   <= teeth_turn_r;
            iter_r  <= 5'(CW - 1);
            state_r <= S_DIVQ;
          end
        end

        // step count quotient, then set up the position modulo
        S_DIVQ: begin
          if (iter_r == '0) begin
            move_cnt_r <= quo_nxt;
            quo_r      <= {sum_mag, {(CW-AW){1'b0}}};
            rem_r      <= '0;
            div_r      <= loop_teeth_r;
            iter_r     <= 5'(AW - 1);
            state_r    <= S_DIVR;
          end else begin
            quo_r  <= quo_nxt;
            rem_r  <= rem_nxt;
            iter_r <= iter_r - 5'd1;
          end
        end

        // position remainder
        S_DIVR: begin
          if (iter_r == '0) begin
            chain_r <= pos_nxt;
            state_r <= S_START;
          end else begin
            quo_r  <= quo_nxt;
            rem_r  <= rem_nxt;
            iter_r <= iter_r - 5'd1;
          end
        end

        // first half-step of a nonzero move
        S_START: begin
          if (move_cnt_r != '0) begin
            ccw_r        <= cmd_ccw_r;
            phase_r      <= cmd_ccw_r ? phase_dn : phase_up;
            energised_r  <= 1'b1;
            steps_left_r <= move_cnt_r - 31'd1;
            delay_left_r <= step_delay_r;
            moving_r     <= 1'b1;
          end
          state_r <= S_FINISH;
        end

        // load the result register once it is free
        S_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            coils_r     <= energised_r ? shs_pkg::phase_pattern(phase_r) : '0;
            busy_r      <= moving_r;
            tooth_r     <= chain_r;
            acc_out_r   <= acc_r;
            phase_out_r <= phase_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------- channel ports ----------------

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.coils          = coils_r;
  assign out_ch.busy_res       = busy_r;
  assign out_ch.tooth_position = tooth_r;
  assign out_ch.accepted       = acc_out_r;
  assign out_ch.phase          = phase_out_r;

  // ---------------- assertions ----------------

  // an idle motor has no steps pending
  a_idle_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
    !moving_r |-> (steps_left_r == '0))
    else $error("steps pending while not moving");

  // a running move keeps the coils energised
  a_moving_energised: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> energised_r)
    else $error("move running with coils off");

  // divider remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIVQ) || (state_r == S_DIVR)) |-> (rem_r < div_r))
    else $error("divider remainder out of range");

  // chain position only changes at the end of the modulo pass
  a_chain_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DIVR) |=> $stable(chain_r))
    else $error("chain position changed outside modulo pass");

endmodule
`default_nettype wire
